// ----- rtl/core/asrd_pkg.sv -----
// Package for the audio silence run detector: constants, register indexes,
// queue entry and status types. No dependencies.
`default_nettype none

package asrd_pkg;

    localparam int unsigned POS_W   = 36;
    localparam int unsigned WIN_W   = 14;
    localparam int unsigned PEAK_W  = 16;
    localparam int unsigned STEP_W  = 13;   // (window + previous window) / 4
    localparam int unsigned RUN_W   = 16;
    localparam int unsigned HOLD_W  = 8;
    localparam int unsigned FOUND_W = 11;
    localparam int unsigned CFG_A_W = 3;

    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 104;
    localparam int unsigned OUT_USER_W = 1;

    localparam logic [HOLD_W-1:0]  HOLD_SHOT    = 8'd25;
    localparam logic [RUN_W-1:0]   MIN_RUN      = 16'd150;
    localparam logic [FOUND_W-1:0] MAX_SEGMENTS = 11'd1024;

    localparam logic [PEAK_W-1:0] THRESHOLD_RST = 16'd328;
    localparam logic [POS_W-1:0]  START_POS_RST = '0;
    localparam logic [WIN_W-1:0]  START_WIN_RST = '0;
    localparam logic              SKIP_LEAD_RST = 1'b0;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [CFG_A_W-1:0] {
        REG_THRESHOLD      = 3'd0,
        REG_SCAN_LIMIT     = 3'd1,
        REG_MIN_LENGTH     = 3'd2,
        REG_START_POSITION = 3'd3,
        REG_GRANULE_OFFSET = 3'd4,
        REG_SKIP_LEADING   = 3'd5,
        REG_START_WINDOW   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic               we;
        logic [CFG_A_W-1:0] addr;
        logic [POS_W-1:0]   data;
    } cfg_wr_t;

    // One classified item on its way from front to back.
    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [POS_W-1:0]  page_pos;
        logic              silent;
        logic              ok;
        logic              new_page;
        logic              last;
    } queue_entry_t;

    typedef struct packed {
        logic               done;
        logic               flush;
        logic [FOUND_W-1:0] found;
    } back_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/asrd_fifo.sv -----
// Short queue between front and back of the silence run detector.
// Depends on asrd_pkg for the queue depth.
`default_nettype none

module asrd_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  not_empty
);
    import asrd_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/asrd_front.sv -----
// Front of the silence run detector: accept items, derive the sample step,
// the offset page position and the silence flag. Depends on asrd_pkg.
`default_nettype none

module asrd_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire asrd_pkg::cfg_wr_t       cfg,
    input  wire logic [15:0]             threshold,
    input  wire logic [35:0]             granule_offset,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [13:0]             window_size,
    input  wire logic [15:0]             peak_level,
    input  wire logic                    decode_ok,
    input  wire logic                    new_page,
    input  wire logic [35:0]             page_granule,
    input  wire logic                    stream_end,
    input  wire logic                    queue_full,
    output logic                         push,
    output asrd_pkg::queue_entry_t       entry
);
    import asrd_pkg::*;

    logic [WIN_W-1:0] prev_window_reg, prev_window_next;
    logic             started_reg, started_next;
    logic [WIN_W:0]   win_sum;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;
    assign win_sum  = {1'b0, window_size} + {1'b0, prev_window_reg};

    always_comb
    begin
        entry.step     = win_sum[WIN_W:2];
        entry.page_pos = (page_granule >= granule_offset) ?
                         page_granule - granule_offset : '0;
        entry.silent   = (peak_level <= threshold);
        entry.ok       = decode_ok;
        entry.new_page = new_page;
        entry.last     = stream_end;
    end

    always_comb
    begin
        prev_window_next = prev_window_reg;
        started_next     = started_reg;
        if (push)
        begin
            prev_window_next = window_size;
            started_next     = 1'b1;
        end
        else if (cfg.we && !started_reg && cfg.addr == REG_START_WINDOW)
        begin
            // before the first item the start window also seeds the history
            prev_window_next = cfg.data[WIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_window_reg <= START_WIN_RST;
            started_reg     <= 1'b0;
        end
        else
        begin
            prev_window_reg <= prev_window_next;
            started_reg     <= started_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/asrd_back.sv -----
// Back of the silence run detector: position tracking, run and hold logic,
// segment reporting and the output register. Depends on asrd_pkg.
`default_nettype none

module asrd_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire asrd_pkg::cfg_wr_t       cfg,
    input  wire logic [35:0]             scan_limit,
    input  wire logic [35:0]             min_length,
    input  wire logic                    entry_valid,
    input  wire asrd_pkg::queue_entry_t  entry,
    output logic                         pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         segment_valid,
    output logic [35:0]                  segment_begin,
    output logic [35:0]                  segment_end,
    output logic [15:0]                  segment_blocks,
    output logic [10:0]                  segments_found,
    output logic                         scan_done,
    output asrd_pkg::back_status_t       status
);
    import asrd_pkg::*;

    logic [POS_W-1:0]   position_reg, position_next;
    logic [POS_W-1:0]   total_reg, total_next;
    logic [POS_W-1:0]   run_begin_reg, run_begin_next;
    logic [POS_W-1:0]   run_end_reg, run_end_next;
    logic [RUN_W-1:0]   run_count_reg, run_count_next;
    logic [HOLD_W-1:0]  hold_reg, hold_next;
    logic               leading_reg, leading_next;
    logic               flush_reg, flush_next;
    logic [FOUND_W-1:0] found_reg, found_next;
    logic               done_reg, done_next;
    logic               eos_reg, eos_next;
    logic               started_reg, started_next;

    logic               out_valid_reg;
    logic               seg_valid_reg, seg_valid_next;
    logic [POS_W-1:0]   seg_begin_reg, seg_begin_next;
    logic [POS_W-1:0]   seg_end_reg, seg_end_next;
    logic [RUN_W-1:0]   seg_blocks_reg, seg_blocks_next;

    logic               active;
    logic [POS_W-1:0]   pos_base;
    logic [POS_W:0]     pos_sum, total_sum;
    logic [POS_W-1:0]   pos_sat, pos_new;
    logic               long_run, close_run, report;
    logic [HOLD_W-1:0]  hold_after;
    logic [HOLD_W:0]    hold_grow;

    assign pop = entry_valid && (!out_valid_reg || out_ready);

    assign out_valid      = out_valid_reg;
    assign segment_valid  = seg_valid_reg;
    assign segment_begin  = seg_begin_reg;
    assign segment_end    = seg_end_reg;
    assign segment_blocks = seg_blocks_reg;
    assign segments_found = found_reg;
    assign scan_done      = done_reg;

    assign status.done  = done_reg;
    assign status.flush = flush_reg;
    assign status.found = found_reg;

    // the first new page after the last page stops the scan
    assign active = !done_reg && !(eos_reg && entry.new_page);

    assign pos_base  = (entry.new_page && position_reg == '0) ? entry.page_pos
                                                              : position_reg;
    assign pos_sum   = {1'b0, pos_base} + (POS_W+1)'(entry.step);
    assign pos_sat   = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
    assign pos_new   = (pos_sat > entry.page_pos) ? entry.page_pos : pos_sat;
    assign total_sum = {1'b0, total_reg} + (POS_W+1)'(entry.step);

    assign long_run   = (run_count_reg > MIN_RUN);
    assign close_run  = long_run && (flush_reg || hold_reg == '0);
    assign report     = close_run && (run_end_reg >= run_begin_reg) &&
                        ((run_end_reg - run_begin_reg) >= min_length);
    assign hold_after = close_run ? HOLD_SHOT : hold_reg;
    assign hold_grow  = {1'b0, hold_reg} + (HOLD_W+1)'(2);

    always_comb
    begin
        position_next   = position_reg;
        total_next      = total_reg;
        run_begin_next  = run_begin_reg;
        run_end_next    = run_end_reg;
        run_count_next  = run_count_reg;
        hold_next       = hold_reg;
        leading_next    = leading_reg;
        flush_next      = flush_reg;
        found_next      = found_reg;
        done_next       = done_reg;
        eos_next        = eos_reg;
        started_next    = started_reg;
        seg_valid_next  = 1'b0;
        seg_begin_next  = '0;
        seg_end_next    = '0;
        seg_blocks_next = '0;

        if (pop)
        begin
            started_next = 1'b1;
            if (!active)
            begin
                done_next = 1'b1;
            end
            else
            begin
                eos_next      = eos_reg || entry.last;
                position_next = pos_new;
                total_next    = total_sum[POS_W] ? '1 : total_sum[POS_W-1:0];

                if (entry.ok)
                begin
                    if (!flush_reg && entry.silent)
                    begin
                        // extend the run
                        if (run_count_reg == '0)
                        begin
                            run_begin_next = pos_new;
                        end
                        if (!leading_reg && run_count_reg != '1)
                        begin
                            run_count_next = run_count_reg + 1'b1;
                        end
                        if (hold_reg < HOLD_SHOT)
                        begin
                            hold_next = hold_grow[HOLD_W] ? '1 : hold_grow[HOLD_W-1:0];
                        end
                        run_end_next = pos_new;
                    end
                    else
                    begin
                        if (close_run)
                        begin
                            if (report)
                            begin
                                seg_valid_next  = 1'b1;
                                seg_begin_next  = run_begin_reg;
                                seg_end_next    = run_end_reg;
                                seg_blocks_next = run_count_reg;
                                found_next      = found_reg + 1'b1;
                            end
                            run_count_next = '0;
                            hold_next      = HOLD_SHOT;
                        end
                        else if (!long_run)
                        begin
                            run_count_next = '0;
                        end

                        if (flush_reg)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            if (leading_reg && hold_after == '0)
                            begin
                                leading_next = 1'b0;
                            end
                            if (hold_after != '0)
                            begin
                                hold_next = hold_after - 1'b1;
                            end
                        end
                    end
                end

                if (!done_next)
                begin
                    if (scan_limit != '0 && total_next > scan_limit)
                    begin
                        flush_next = 1'b1;
                    end
                    if (found_next >= MAX_SEGMENTS)
                    begin
                        done_next = 1'b1;
                    end
                end
            end
        end
        else if (cfg.we && !started_reg)
        begin
            // before the first item the start registers also seed the state
            if (cfg.addr == REG_START_POSITION)
            begin
                position_next  = cfg.data;
                run_begin_next = cfg.data;
                run_end_next   = cfg.data;
            end
            if (cfg.addr == REG_SKIP_LEADING)
            begin
                leading_next = cfg.data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= START_POS_RST;
            total_reg     <= '0;
            run_begin_reg <= START_POS_RST;
            run_end_reg   <= START_POS_RST;
            run_count_reg <= '0;
            hold_reg      <= HOLD_SHOT;
            leading_reg   <= SKIP_LEAD_RST;
            flush_reg     <= 1'b0;
            found_reg     <= '0;
            done_reg      <= 1'b0;
            eos_reg       <= 1'b0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            position_reg  <= position_next;
            total_reg     <= total_next;
            run_begin_reg <= run_begin_next;
            run_end_reg   <= run_end_next;
            run_count_reg <= run_count_next;
            hold_reg      <= hold_next;
            leading_reg   <= leading_next;
            flush_reg     <= flush_next;
            found_reg     <= found_next;
            done_reg      <= done_next;
            eos_reg       <= eos_next;
            started_reg   <= started_next;
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            seg_valid_reg  <= seg_valid_next;
            seg_begin_reg  <= seg_begin_next;
            seg_end_reg    <= seg_end_next;
            seg_blocks_reg <= seg_blocks_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/audio_silence_run_detector.sv -----
// Top level of the audio silence run detector: configuration registers,
// front, queue and back. Depends on asrd_pkg, asrd_front, asrd_fifo, asrd_back.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tdata: window, peak, granule; tuser: ok, new page;
//                                    tlast: stream end
//  m_*      out  m_tvalid/m_tready   tdata: begin, end, blocks, found; tuser: segment;
//                                    tlast: scan done
//  cfg_*    in   cfg_we              cfg_addr register index, cfg_data value
//
// One item per cycle while m_tready keeps the output moving; each accepted item
// yields one result, registered through the queue and then the back's output register.
// The back's combinational state update (position add, clamp, run compares)
// sets that rate. Reset is asynchronous and returns the control state to its
// reset values; queue storage and the segment output registers are not reset.
// A stalled output fills the two-entry queue, then drops s_tready.
`default_nettype none

module audio_silence_run_detector (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [13:0] window_size, [29:14] peak_level, [65:30] page_granule, rest zero
    input  wire logic [71:0]  s_tdata,
    // [0] decode_ok, [1] new_page
    input  wire logic [1:0]   s_tuser,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [35:0] segment_begin, [71:36] segment_end, [87:72] segment_blocks,
    // [98:88] segments_found, rest zero
    output logic [103:0]      m_tdata,
    // [0] segment_valid
    output logic [0:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [35:0]  cfg_data
);
    import asrd_pkg::*;

    logic [PEAK_W-1:0] threshold_reg;
    logic [POS_W-1:0]  scan_limit_reg;
    logic [POS_W-1:0]  min_length_reg;
    logic [POS_W-1:0]  granule_offset_reg;

    cfg_wr_t       cfg;
    queue_entry_t  front_entry, back_entry;
    back_status_t  status;
    logic          push, queue_full, pop, queue_valid;

    logic [POS_W-1:0]   seg_begin, seg_end;
    logic [RUN_W-1:0]   seg_blocks;
    logic [FOUND_W-1:0] seg_found;

    assign cfg.we   = cfg_we;
    assign cfg.addr = cfg_addr;
    assign cfg.data = cfg_data;

    // Hold the registers the datapath reads. Start position, skip-leading and
    // start window only seed state, so front and back take them off the port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg      <= THRESHOLD_RST;
            scan_limit_reg     <= '0;
            min_length_reg     <= '0;
            granule_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_THRESHOLD:      threshold_reg      <= cfg_data[PEAK_W-1:0];
                REG_SCAN_LIMIT:     scan_limit_reg     <= cfg_data;
                REG_MIN_LENGTH:     min_length_reg     <= cfg_data;
                REG_GRANULE_OFFSET: granule_offset_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Front: classify each item as it arrives.
    asrd_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .threshold      (threshold_reg),
        .granule_offset (granule_offset_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .window_size    (s_tdata[13:0]),
        .peak_level     (s_tdata[29:14]),
        .decode_ok      (s_tuser[0]),
        .new_page       (s_tuser[1]),
        .page_granule   (s_tdata[65:30]),
        .stream_end     (s_tlast),
        .queue_full     (queue_full),
        .push           (push),
        .entry          (front_entry)
    );

    // Queue: decouple front from back so output stalls do not ripple at once.
    asrd_fifo #(
        .WIDTH ($bits(queue_entry_t))
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_entry),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (back_entry),
        .not_empty (queue_valid)
    );

    // Back: advance position and run state, register the result.
    asrd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .scan_limit     (scan_limit_reg),
        .min_length     (min_length_reg),
        .entry_valid    (queue_valid),
        .entry          (back_entry),
        .pop            (pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .segment_valid  (m_tuser[0]),
        .segment_begin  (seg_begin),
        .segment_end    (seg_end),
        .segment_blocks (seg_blocks),
        .segments_found (seg_found),
        .scan_done      (m_tlast),
        .status         (status)
    );

    assign m_tdata = {5'b0, seg_found, seg_blocks, seg_end, seg_begin};

    // Once stopped, the scan stays stopped.
    a_done_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        status.done |=> status.done)
        else $error("scan restarted after stop");

    // Flush never clears once raised.
    a_flush_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        status.flush |=> status.flush)
        else $error("flush dropped");

    // A reported segment never runs backwards.
    a_seg_order : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (seg_end >= seg_begin))
        else $error("segment end before begin");

    // The segment count never passes the cap.
    a_found_cap : assert property (@(posedge clk) disable iff (!rst_n)
        status.found <= MAX_SEGMENTS)
        else $error("segment count above cap");

endmodule

`default_nettype wire
